[rtl/core/pce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printer carriage encoder package
// Shared types, codes and constants for the carriage stepper and its top level.
// ----------------------------------------------------------------------------
package pce_pkg;

	// Printer line length in pixels, the default for the top-level parameter.
	localparam int LinePixelsDefault = 256;

	// Widths of the item and state fields.
	localparam int KindW   = 2;
	localparam int TicksW  = 10;
	localparam int ByteW   = 8;
	localparam int PosW    = 9;
	localparam int TimerW  = 12;
	localparam int GapW    = 10;

	// Reset and limit values.
	localparam logic [GapW-1:0]          GapAfterReset = 10'd16;
	localparam logic [GapW-1:0]          GapMax        = 10'd1023;
	localparam logic signed [TimerW-1:0] TimerReset    = 12'sd25;
	localparam logic signed [TimerW-1:0] TimerMax      = 12'sd2047;
	localparam logic signed [TimerW-1:0] TimerMin      = -12'sd2048;
	localparam logic [PosW-1:0]          LineEndShort  = 9'd257;
	localparam logic [PosW-1:0]          LineEndLong   = 9'd258;

	// Reset register values: bit_speed 34 gives a reload of 16 + 10 * 34.
	localparam logic signed [TimerW-1:0] ReloadReset    = 12'sd356;
	localparam logic [GapW-1:0]          GapReloadReset = 10'd1;

	// Port bits of a written byte.
	localparam int WrResetBit  = 2;
	localparam int WrStylusBit = 7;

	// Item kinds.
	typedef enum logic [KindW-1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CfgBitSpeed  = 2'd0;
	localparam logic [1:0] CfgLineSpeed = 2'd1;
	localparam logic [1:0] CfgShortLine = 2'd2;

	// Derived configuration seen by the stepper.
	typedef struct packed {
		logic signed [TimerW-1:0] timer_reload;
		logic [GapW-1:0]          gap_reload;
		logic                     short_line;
	} cfg_t;

	// Printer state.
	typedef struct packed {
		logic                     motor_running;
		logic                     stylus_on;
		logic                     on_paper;
		logic                     encoder;
		logic [PosW-1:0]          carriage_pos;
		logic signed [TimerW-1:0] bit_timer;
		logic [GapW-1:0]          gap_count;
	} state_t;

	// One input item.
	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [TicksW-1:0] tick_cycles;
		logic [ByteW-1:0]  write_data;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [ByteW-1:0] read_data;
		logic             pixel_valid;
		logic [7:0]       pixel_x;
		logic             pixel_ink;
		logic             line_feed;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/pce_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printer carriage stepper
// Combinational next-state and result logic for one tick, write or read item.
// ----------------------------------------------------------------------------
module pce_step #(
	parameter int LINE_PIXELS = pce_pkg::LinePixelsDefault
) (
	input  wire pce_pkg::cfg_t    cfg,
	input  wire pce_pkg::state_t  cur,
	input  wire pce_pkg::item_t   item,
	output pce_pkg::state_t       nxt,
	output pce_pkg::result_t      res
);

	// Highest position that places a pixel; the column must also fit in 8 bits.
	localparam int PixLimit = (LINE_PIXELS < 256) ? LINE_PIXELS : 256;
	localparam int TW       = pce_pkg::TimerW;

	logic signed [TW:0]   timer_sub;
	logic signed [TW-1:0] timer_sub_c;
	logic signed [TW:0]   timer_add;
	logic signed [TW-1:0] timer_add_c;
	logic [pce_pkg::PosW-1:0] pos_inc;
	logic [pce_pkg::PosW-1:0] line_end;

	// Bit timer countdown and reload, each saturated to the timer range.
	always_comb begin
		timer_sub = {cur.bit_timer[TW-1], cur.bit_timer} -
			$signed({3'b000, item.tick_cycles});
		if (timer_sub < $signed({pce_pkg::TimerMin[TW-1], pce_pkg::TimerMin})) begin
			timer_sub_c = pce_pkg::TimerMin;
		end else begin
			timer_sub_c = timer_sub[TW-1:0];
		end
		timer_add = {timer_sub_c[TW-1], timer_sub_c} +
			{cfg.timer_reload[TW-1], cfg.timer_reload};
		if (timer_add > $signed({pce_pkg::TimerMax[TW-1], pce_pkg::TimerMax})) begin
			timer_add_c = pce_pkg::TimerMax;
		end else if (timer_add < $signed({pce_pkg::TimerMin[TW-1], pce_pkg::TimerMin}))
		begin
			timer_add_c = pce_pkg::TimerMin;
		end else begin
			timer_add_c = timer_add[TW-1:0];
		end
	end

	assign pos_inc  = cur.carriage_pos + 9'd1;
	assign line_end = cfg.short_line ? pce_pkg::LineEndShort : pce_pkg::LineEndLong;

	// Item decode and state update.
	always_comb begin
		nxt = cur;
		res = '0;
		case (item.kind)
			pce_pkg::KIND_TICK: begin
				if (cur.motor_running) begin
					nxt.bit_timer = timer_sub_c;
					if (timer_sub_c <= 0) begin
						nxt.bit_timer = timer_add_c;
						if (cur.gap_count != '0) begin
							// Still crossing the gap before the paper.
							nxt.on_paper  = 1'b0;
							nxt.encoder   = 1'b0;
							nxt.gap_count = cur.gap_count - 10'd1;
						end else begin
							nxt.on_paper = 1'b1;
							nxt.encoder  = 1'b1;
							if (cur.carriage_pos != '0 &&
								cur.carriage_pos <= pce_pkg::PosW'(PixLimit)) begin
								res.pixel_valid = 1'b1;
								res.pixel_x     = 8'(cur.carriage_pos - 9'd1);
								res.pixel_ink   = cur.stylus_on;
							end
							nxt.carriage_pos = pos_inc;
							// End of the line: feed the paper and reload the gap.
							if (pos_inc == line_end) begin
								res.line_feed    = 1'b1;
								nxt.on_paper     = 1'b0;
								nxt.encoder      = 1'b0;
								nxt.carriage_pos = '0;
								nxt.gap_count    = cfg.gap_reload;
							end
						end
					end
				end
			end
			pce_pkg::KIND_WRITE: begin
				if (item.write_data[pce_pkg::WrResetBit]) begin
					nxt.motor_running = 1'b0;
					res.line_feed     = (cur.carriage_pos != '0);
					nxt.carriage_pos  = '0;
					nxt.gap_count     = pce_pkg::GapAfterReset;
				end else begin
					nxt.motor_running = 1'b1;
				end
				nxt.stylus_on = item.write_data[pce_pkg::WrStylusBit];
				nxt.on_paper  = 1'b0;
				nxt.encoder   = 1'b0;
			end
			pce_pkg::KIND_READ: begin
				res.read_data = {cur.on_paper, 6'b000000, cur.encoder};
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/printer_carriage_encoder_model.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Printer carriage encoder model
// Stylus printer port model: ticks drive the carriage, writes control the
// motor and stylus, reads return the on-paper and encoder flags.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tuser: kind; tdata: ticks, byte
//  m_*      out        m_tvalid/m_tready  tdata: read, pixel, line feed
//  cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// One result per item, via the input register then the result register; one item
// per cycle sustained while the result side keeps up; the printer state update
// is combinational around the state registers. Reset clears the state to the
// power-on printer. A stall on the result side holds the result register, then
// the input register, and then drops s_tready. Configuration is always ready and takes effect at once.
// ----------------------------------------------------------------------------
module printer_carriage_encoder_model #(
	parameter int LINE_PIXELS = pce_pkg::LinePixelsDefault
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // tick_cycles[9:0], write_data[17:10], zeros
	input  wire  [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // read_data[7:0], pixel_valid[8],
	                               // pixel_x[16:9], pixel_ink[17], line_feed[18]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [7:0]  cfg_data
);

	pce_pkg::cfg_t    cfg_q;
	pce_pkg::state_t  state_q;
	pce_pkg::state_t  state_nxt;
	pce_pkg::item_t   item_s1;
	pce_pkg::result_t res_nxt;
	pce_pkg::result_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;

	logic signed [pce_pkg::TimerW-1:0] bs_ext;
	logic [10:0]                       gap_calc;

	assign cfg_ready = 1'b1;

	// Reload values are derived when a register is written.
	assign bs_ext   = {{(pce_pkg::TimerW-8){cfg_data[7]}}, cfg_data};
	assign gap_calc = ({4'b0000, cfg_data[6:0]} << 3) + ({4'b0000, cfg_data[6:0]} << 1)
		+ 11'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_reload <= pce_pkg::ReloadReset;
			cfg_q.gap_reload   <= pce_pkg::GapReloadReset;
			cfg_q.short_line   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pce_pkg::CfgBitSpeed: begin
					cfg_q.timer_reload <= (bs_ext <<< 3) + (bs_ext <<< 1) + 12'sd16;
				end
				pce_pkg::CfgLineSpeed: begin
					cfg_q.gap_reload <= (gap_calc > {1'b0, pce_pkg::GapMax}) ?
						pce_pkg::GapMax : gap_calc[pce_pkg::GapW-1:0];
				end
				pce_pkg::CfgShortLine: begin
					cfg_q.short_line <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register stage.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind        <= s_tuser;
			item_s1.tick_cycles <= s_tdata[9:0];
			item_s1.write_data  <= s_tdata[17:10];
		end
	end

	pce_step #(
		.LINE_PIXELS(LINE_PIXELS)
	) u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Printer state, updated as each item moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.motor_running <= 1'b0;
			state_q.stylus_on     <= 1'b0;
			state_q.on_paper      <= 1'b0;
			state_q.encoder       <= 1'b0;
			state_q.carriage_pos  <= '0;
			state_q.bit_timer     <= pce_pkg::TimerReset;
			state_q.gap_count     <= pce_pkg::GapAfterReset;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, res_q.line_feed, res_q.pixel_ink, res_q.pixel_x,
		res_q.pixel_valid, res_q.read_data};

endmodule
`default_nettype wire

[tb/printer_carriage_encoder_model_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printer carriage encoder model testbench
// Drives ticks, port writes and port reads through the input stream. An
// in-bench printer model predicts each result, and the monitor checks the
// results in order. The run steps through several speed and line settings
// and uses random idling on both sides, a long receiver hold-off and a drain
// pause mid-phase.
// ----------------------------------------------------------------------------
module printer_carriage_encoder_model_tb;
	import pce_pkg::*;

	localparam int LinePixels     = LinePixelsDefault;
	localparam int TimerBase      = 1016;
	localparam int SinkHoldCycles = 400;
	localparam int CycleLimit     = 400000;
	localparam int PhaseItems     = 120;
	localparam logic [1:0] CfgUnused = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// Stimulus and expectation stores.
	item_t   port_requests[$];
	result_t printer_results_due[$];

	// Idling controls.
	logic src_bursts = 1'b0;
	logic sink_bursts = 1'b0;
	logic start_hold = 1'b0;
	logic sink_hold = 1'b0;
	int   src_gap = 0;
	int   sink_gap = 0;
	int   mismatches = 0;
	int   cycle_count = 0;

	// Predicted printer configuration.
	logic signed [7:0] bit_speed = 8'sd34;
	logic [6:0]        line_speed = 7'd0;
	logic              short_line = 1'b0;

	// Predicted printer state.
	logic            motor_on = 1'b0;
	logic            stylus = 1'b0;
	logic            on_paper = 1'b0;
	logic            encoder = 1'b0;
	logic [PosW-1:0] carriage_pos = '0;
	int              carriage_timer = int'(TimerReset);
	logic [GapW-1:0] gap_left = GapAfterReset;

	printer_carriage_encoder_model #(
		.LINE_PIXELS(LinePixels)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Saturate to the signed range of the bit timer.
	function automatic int clamp_timer(input int v);
		if (v > int'(TimerMax)) return int'(TimerMax);
		if (v < int'(TimerMin)) return int'(TimerMin);
		return v;
	endfunction

	// Advance the printer model by one request and return its result.
	function automatic result_t predict_printer(input logic [1:0] kind,
			input logic [TicksW-1:0] ticks, input logic [ByteW-1:0] wbyte);
		result_t r;
		int t;
		int g;
		r = '0;
		case (kind)
			KIND_TICK: begin
				if (motor_on) begin
					t = clamp_timer(carriage_timer - int'(ticks));
					if (t > 0) begin
						carriage_timer = t;
					end else begin
						// One carriage step per expiry, however many elapsed.
						carriage_timer = clamp_timer(t + TimerBase
							- (100 - int'(bit_speed)) * 10);
						if (gap_left != 0) begin
							on_paper = 1'b0;
							encoder = 1'b0;
							gap_left = gap_left - 1'b1;
						end else begin
							on_paper = 1'b1;
							encoder = 1'b1;
							if (carriage_pos >= 1 && carriage_pos <= LinePixels
									&& carriage_pos <= 256) begin
								r.pixel_valid = 1'b1;
								r.pixel_x = 8'(carriage_pos - 1'b1);
								r.pixel_ink = stylus;
							end
							carriage_pos = carriage_pos + 1'b1;
							if (carriage_pos == (short_line ? LineEndShort : LineEndLong)) begin
								g = 1 + int'(line_speed) * 10;
								r.line_feed = 1'b1;
								on_paper = 1'b0;
								encoder = 1'b0;
								carriage_pos = '0;
								gap_left = (g > int'(GapMax)) ? GapMax : GapW'(g);
							end
						end
					end
				end
			end
			KIND_WRITE: begin
				if (wbyte[WrResetBit]) begin
					// Printer reset: feed a line if the carriage left home.
					motor_on = 1'b0;
					r.line_feed = (carriage_pos != 0);
					carriage_pos = '0;
					gap_left = GapAfterReset;
				end else begin
					motor_on = 1'b1;
				end
				stylus = wbyte[WrStylusBit];
				on_paper = 1'b0;
				encoder = 1'b0;
			end
			KIND_READ: begin
				r.read_data = {on_paper, 6'd0, encoder};
			end
			default: ;
		endcase
		return r;
	endfunction

	// Count and print one mismatch.
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic add_item(input logic [1:0] kind, input int ticks, input int wbyte);
		item_t it;
		it.kind = kind;
		it.tick_cycles = ticks[TicksW-1:0];
		it.write_data = wbyte[ByteW-1:0];
		port_requests.push_back(it);
	endtask

	// Mostly long ticks so the timer expires often, sometimes any length.
	function automatic int pick_ticks();
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1023);
		return $urandom_range(700, 1023);
	endfunction

	// Carriage runs: a motor start, then ticks with reads mixed in, with
	// occasional printer resets and stray requests between runs.
	task automatic queue_random(input int count);
		int left;
		int run;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 4) == 0) begin
				add_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
					$urandom_range(0, 255));
				left--;
			end else begin
				add_item(KIND_WRITE, $urandom_range(0, 1023),
					$urandom_range(0, 255) & ~(1 << WrResetBit));
				run = $urandom_range(10, 150);
				// Shorten the last run to fit the remaining count with its motor start, keeping one item at least.
				if (run >= left)
					run = (left > 1) ? left - 1 : 1;
				repeat (run) begin
					if ($urandom_range(0, 9) == 0)
						add_item(KIND_READ, $urandom_range(0, 1023), $urandom_range(0, 255));
					else
						add_item(KIND_TICK, pick_ticks(), $urandom_range(0, 255));
				end
				left -= run + 1;
				if ($urandom_range(0, 3) == 0) begin
					add_item(KIND_WRITE, $urandom_range(0, 1023),
						$urandom_range(0, 255) | (1 << WrResetBit));
					left--;
				end
			end
		end
	endtask

	// Wait until every request has been sent and every result has come back.
	task automatic settle();
		do @(posedge clk);
		while (port_requests.size() != 0 || s_tvalid || printer_results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write one configuration register and mirror it in the model.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CfgBitSpeed:  bit_speed = val;
			CfgLineSpeed: line_speed = val[6:0];
			CfgShortLine: short_line = val[0];
			default: ;
		endcase
	endtask

	// Request driver: offers queued items, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin : request_driver
		item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				printer_results_due.push_back(predict_printer(s_tuser, s_tdata[9:0],
					s_tdata[17:10]));
			if (!s_tvalid || s_tready) begin
				if (src_gap == 0 && src_bursts && $urandom_range(0, 9) == 0)
					src_gap = $urandom_range(1, 15);
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (port_requests.size() != 0) begin
					nxt = port_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, nxt.write_data, nxt.tick_cycles};
					s_tuser <= nxt.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (printer_results_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no request pending", m_tdata));
				end else begin
					want = printer_results_due.pop_front();
					check_field("read_data", m_tdata[7:0], want.read_data);
					check_field("pixel_valid", m_tdata[8], want.pixel_valid);
					check_field("pixel_x", m_tdata[16:9], want.pixel_x);
					check_field("pixel_ink", m_tdata[17], want.pixel_ink);
					check_field("line_feed", m_tdata[18], want.line_feed);
				end
			end
			if (sink_gap == 0 && sink_bursts && $urandom_range(0, 9) == 0)
				sink_gap = $urandom_range(1, 15);
			if (sink_hold) begin
				m_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off so the block fills and stalls its input.
	initial begin : sink_hold_off
		wait (start_hold);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (SinkHoldCycles) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin : test_sequence
		logic [7:0] speed_set [5] = '{8'd99, 8'hFF, 8'h80, 8'h7F, 8'd0};
		logic [7:0] line_set  [5] = '{8'd100, 8'hFF, 8'h00, 8'h25, 8'd1};
		logic [7:0] short_set [5] = '{8'd1, 8'h00, 8'hFF, 8'hFE, 8'd1};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_bursts <= 1'b1;
		sink_bursts <= 1'b1;

		// Directed requests at reset settings.
		add_item(KIND_READ, 0, 0);
		add_item(KIND_TICK, 1023, 0);            // motor stopped
		add_item(2'd3, 1023, 8'hFF);             // unused kind
		add_item(KIND_WRITE, 0, 8'h00);          // motor start
		add_item(KIND_TICK, 0, 0);
		add_item(KIND_TICK, 24, 0);
		add_item(KIND_TICK, 1, 0);               // timer reaches zero
		add_item(KIND_TICK, 1023, 8'hFF);        // several expiries, one step
		add_item(KIND_WRITE, 0, 8'h04);          // reset at home, no feed
		add_item(KIND_WRITE, 1023, 8'hFF);
		add_item(KIND_WRITE, 0, 8'h80);          // start with the stylus down
		repeat (18) add_item(KIND_TICK, 1023, 0); // through the gap onto paper
		add_item(KIND_READ, 0, 0);
		add_item(KIND_WRITE, 0, 8'h84);          // reset off home feeds a line
		settle();

		// Sweep the configuration, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CfgBitSpeed, speed_set[ph]);
			write_reg(CfgLineSpeed, line_set[ph]);
			write_reg(CfgShortLine, short_set[ph]);
			if (ph == 0) begin
				src_bursts <= 1'b0;
				start_hold <= 1'b1;
			end
			queue_random(PhaseItems);
			settle();
			src_bursts <= 1'b1;
			queue_random(PhaseItems);
			settle();
		end

		// Back to reset settings with no idling for the last part.
		write_reg(CfgUnused, 8'hA5);
		write_reg(CfgBitSpeed, 8'd34);
		write_reg(CfgLineSpeed, 8'd0);
		write_reg(CfgShortLine, 8'd0);
		src_bursts <= 1'b0;
		sink_bursts <= 1'b0;
		queue_random(2 * PhaseItems);
		settle();
		repeat (10) @(posedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/pce_pkg.sv
rtl/core/pce_step.sv
rtl/core/printer_carriage_encoder_model.sv
tb/printer_carriage_encoder_model_tb.sv
